FILE: sv/base64_stream_codec_core_macros.svh
// ----------------------------------------------------------------------------
// base64_stream_codec_core_macros
// assertion macros used by the checker file of the codec
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define B64C_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64c assertion failed");

// next-cycle implication, disabled during reset
`define B64C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64c assertion failed");

`endif

FILE: sv/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// types, constants and character mapping functions of the base64 codec
// ----------------------------------------------------------------------------
package b64c_pkg;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       out_error;
   } rsp_type;

   // results of one transaction, entries 0 .. last_idx are valid
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            last;
      logic            error;
   } bundle_type;

   function automatic logic [7:0] enc_char(input logic [5:0] s);
      logic [7:0] w;
      begin
         w = {2'b00, s};
         if (s < 6'd26) begin
            enc_char = w + 8'd65;
         end else if (s < 6'd52) begin
            enc_char = w + 8'd71;
         end else if (s < 6'd62) begin
            enc_char = w - 8'd4;
         end else if (s == 6'd62) begin
            enc_char = 8'h2B;
         end else begin
            enc_char = 8'h2F;
         end
      end
   endfunction

   // characters outside the alphabet map to zero
   function automatic logic [5:0] dec_sextet(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'h00;
         if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'd65;
         end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'd71;
         end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'd4;
         end else if (c == 8'h2B) begin
            d = 8'd62;
         end else if (c == 8'h2F) begin
            d = 8'd63;
         end
         dec_sextet = d[5:0];
      end
   endfunction

endpackage

FILE: sv/b64c_group.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_group
// group state, direction register and per-transaction result bundle
// ----------------------------------------------------------------------------
module b64c_group (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_wdata,
   input  logic                req_valid,
   input  b64c_pkg::req_type   req_data,
   output logic                req_stall,
   input  logic                free,
   output logic                load,
   output b64c_pkg::bundle_type bundle
);
   import b64c_pkg::*;

   logic        dir_ff;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  pads_ff, pads_in;

   logic [1:0]  enc_cnt;
   logic [5:0]  sextet;
   logic        is_pad;
   logic [23:0] g;
   logic [1:0]  pads_n;
   logic        produces;
   logic        accept;

   always_comb begin
      enc_cnt  = (count_ff == 2'd3) ? 2'd0 : count_ff;
      sextet   = dec_sextet(req_data.in_byte);
      is_pad   = (req_data.in_byte == PAD_CHAR);
      g        = bits_ff;
      pads_n   = pads_ff;
      produces = 1'b0;
      bundle   = '0;
      bits_in  = bits_ff;
      count_in = count_ff;
      pads_in  = pads_ff;
      if (dir_ff == DIR_ENCODE) begin
         unique case (enc_cnt)
            2'd0:    g = bits_ff | {req_data.in_byte, 16'h0000};
            2'd1:    g = bits_ff | {8'h00, req_data.in_byte, 8'h00};
            default: g = bits_ff | {16'h0000, req_data.in_byte};
         endcase
         produces = (enc_cnt == 2'd2) || req_data.in_last;
         bundle.bytes[0] = enc_char(g[23:18]);
         bundle.bytes[1] = enc_char(g[17:12]);
         bundle.bytes[2] = (enc_cnt != 2'd0) ? enc_char(g[11:6]) : PAD_CHAR;
         bundle.bytes[3] = (enc_cnt == 2'd2) ? enc_char(g[5:0]) : PAD_CHAR;
         bundle.last_idx = 2'd3;
         bundle.last     = req_data.in_last;
         bundle.error    = 1'b0;
         bits_in  = g;
         count_in = enc_cnt + 2'd1;
      end else begin
         pads_n = pads_ff | {is_pad && (count_ff == 2'd3), is_pad && (count_ff == 2'd2)};
         unique case (count_ff)
            2'd0:    g = bits_ff | {sextet, 18'h00000};
            2'd1:    g = bits_ff | {6'h00, sextet, 12'h000};
            2'd2:    g = bits_ff | {12'h000, sextet, 6'h00};
            default: g = bits_ff | {18'h00000, sextet};
         endcase
         produces = (count_ff == 2'd3) || req_data.in_last;
         if (count_ff == 2'd3) begin
            // skipped bytes are squeezed out so the list stays contiguous
            bundle.bytes[0] = g[23:16];
            bundle.bytes[1] = pads_n[0] ? g[7:0] : g[15:8];
            bundle.bytes[2] = g[7:0];
            bundle.bytes[3] = BYTE_ZERO;
            bundle.last_idx = 2'd2 - {1'b0, pads_n[0]} - {1'b0, pads_n[1]};
            bundle.last     = req_data.in_last;
            bundle.error    = 1'b0;
         end else begin
            // partial group at end of stream
            bundle.bytes    = '0;
            bundle.last_idx = 2'd0;
            bundle.last     = 1'b1;
            bundle.error    = 1'b1;
         end
         bits_in  = g;
         count_in = count_ff + 2'd1;
         pads_in  = pads_n;
      end
      if (produces) begin
         bits_in  = '0;
         count_in = 2'd0;
         pads_in  = 2'd0;
      end
   end

   assign req_stall = produces && !free;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && produces;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_ENCODE;
         bits_ff  <= '0;
         count_ff <= 2'd0;
         pads_ff  <= 2'd0;
      end else if (csr_write) begin
         dir_ff   <= csr_wdata;
         bits_ff  <= '0;
         count_ff <= 2'd0;
         pads_ff  <= 2'd0;
      end else if (accept) begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         pads_ff  <= pads_in;
      end
   end

endmodule

FILE: sv/b64c_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_drain
// bundle register, hands results out one per transaction
// ----------------------------------------------------------------------------
module b64c_drain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  b64c_pkg::bundle_type bundle,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output b64c_pkg::rsp_type    rsp_data
);
   import b64c_pkg::*;

   bundle_type  bundle_ff;
   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic        at_final;
   logic        rsp_take;

   assign at_final  = (idx_ff == bundle_ff.last_idx);
   assign rsp_take  = valid_ff && !rsp_stall;
   assign free      = !valid_ff || (rsp_take && at_final);
   assign rsp_valid = valid_ff;

   assign rsp_data.out_byte  = bundle_ff.bytes[idx_ff];
   assign rsp_data.out_last  = bundle_ff.last && at_final;
   assign rsp_data.out_error = bundle_ff.error && at_final;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (rsp_take) begin
         if (at_final) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

endmodule

FILE: sv/base64_stream_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_core
// streaming base64 encoder / decoder, direction chosen by a register
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+---------------------------
//  req     | req_valid, req_stall, req_data | bytes or characters in
//  rsp     | rsp_valid, rsp_stall, rsp_data | characters or bytes out
//  csr     | csr_valid, csr_ready, csr_wdata| direction register write
//
//  one req transaction per cycle while req_stall is low; a transaction that
//  closes a group loads up to four results into the bundle register, which
//  drains at one rsp transaction per cycle while rsp_stall is low. req_stall
//  rises only for a group-closing transaction while the bundle still drains.
//  synchronous reset clears direction (encode) and group state.
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64c_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64c_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);
   import b64c_pkg::*;

   bundle_type bundle;
   logic       load;
   logic       free;
   logic       csr_write;

   // direction only changes with no results pending
   assign csr_ready = !rsp_valid;
   assign csr_write = csr_valid && csr_ready;

   b64c_group u_group (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .free      (free),
      .load      (load),
      .bundle    (bundle)
   );

   b64c_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/b64c_checker.sv
`timescale 1ns / 1ps
`include "base64_stream_codec_core_macros.svh"
// ----------------------------------------------------------------------------
// b64c_checker
// port-level checks of the codec, bound to the top level
// ----------------------------------------------------------------------------
module b64c_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input b64c_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input b64c_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              csr_wdata
);
   import b64c_pkg::*;

   // a stalled result holds
   `B64C_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // error only flags the end of a stream
   `B64C_ASSERT_IMPL(a_err_last, clock, reset, rsp_valid && rsp_data.out_error, rsp_data.out_last)

   // no register write while results are pending
   `B64C_ASSERT_IMPL(a_csr_idle, clock, reset, csr_ready, !rsp_valid)

   // nothing comes out in the cycle after reset
   `B64C_ASSERT_IMPL(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind base64_stream_codec_core b64c_checker u_b64c_checker (.*);
